[design/tegc_pkg.sv]
`default_nettype none

package tegc_pkg;

	localparam int unsigned COORD_BITS_DEF = 12;

	// event codes
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_DOWN = 3'd1;
	localparam logic [2:0] EV_MOVE = 3'd2;
	localparam logic [2:0] EV_HOLD = 3'd3;
	localparam logic [2:0] EV_UP   = 3'd4;

	// gesture codes
	localparam logic [2:0] GS_NONE  = 3'd0;
	localparam logic [2:0] GS_TAP   = 3'd1;
	localparam logic [2:0] GS_LEFT  = 3'd2;
	localparam logic [2:0] GS_RIGHT = 3'd3;
	localparam logic [2:0] GS_UP    = 3'd4;
	localparam logic [2:0] GS_DOWN  = 3'd5;

	// register indexes
	localparam logic CFG_ENABLED = 1'b0;
	localparam logic CFG_THRESH  = 1'b1;

	localparam logic [3:0] THR_MIN = 4'd1;
	localparam logic [3:0] THR_MAX = 4'd10;
	localparam logic [3:0] THR_RST = 4'd5;

	localparam logic [31:0] HOLD_MS  = 32'd500;
	localparam logic [31:0] TAP_MS   = 32'd200;
	localparam int unsigned TAP_PX   = 20;
	localparam int unsigned SWIPE_PX = 50;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [2:0] gesture_kind;
		logic       touch_active;
	} evt_ctl_t;

endpackage

`default_nettype wire

[design/tegc_core.sv]
`default_nettype none

module tegc_core #(
	parameter int unsigned COORD_BITS = tegc_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic [3:0]                   thr,
	input  wire logic                         fire,
	input  wire logic                         pressed,
	input  wire logic [COORD_BITS-1:0]        sample_x,
	input  wire logic [COORD_BITS-1:0]        sample_y,
	input  wire logic [31:0]                  now_ms,
	output tegc_pkg::evt_ctl_t                ctl,
	output logic      [COORD_BITS-1:0]        event_x,
	output logic      [COORD_BITS-1:0]        event_y,
	output logic      [31:0]                  held_ms,
	output logic signed [COORD_BITS:0]        gesture_dx,
	output logic signed [COORD_BITS:0]        gesture_dy
);

	localparam int unsigned C = COORD_BITS;
	localparam logic [C:0] TAP_W   = (C+1)'(tegc_pkg::TAP_PX);
	localparam logic [C:0] SWIPE_W = (C+1)'(tegc_pkg::SWIPE_PX);

	logic          pressed_q;
	logic [31:0]   start_time_q;
	logic [C-1:0]  start_x_q, start_y_q, last_x_q, last_y_q;

	logic          pressed_nxt;
	logic [31:0]   start_time_nxt;
	logic [C-1:0]  start_x_nxt, start_y_nxt, last_x_nxt, last_y_nxt;

	logic signed [C:0] mdx, mdy, gdx, gdy;
	logic [C:0]        amdx, amdy, agdx, agdy, thr_w;
	logic [31:0]       dur;
	logic              is_move, is_tap, is_swipe;
	logic [2:0]        gk;

	assign dur   = now_ms - start_time_q;
	assign mdx   = $signed({1'b0, sample_x}) - $signed({1'b0, last_x_q});
	assign mdy   = $signed({1'b0, sample_y}) - $signed({1'b0, last_y_q});
	assign gdx   = $signed({1'b0, last_x_q}) - $signed({1'b0, start_x_q});
	assign gdy   = $signed({1'b0, last_y_q}) - $signed({1'b0, start_y_q});
	assign amdx  = mdx[C] ? $unsigned(-mdx) : $unsigned(mdx);
	assign amdy  = mdy[C] ? $unsigned(-mdy) : $unsigned(mdy);
	assign agdx  = gdx[C] ? $unsigned(-gdx) : $unsigned(gdx);
	assign agdy  = gdy[C] ? $unsigned(-gdy) : $unsigned(gdy);
	assign thr_w = (C+1)'(thr);

	assign is_move  = (amdx > thr_w) || (amdy > thr_w);
	assign is_tap   = (dur < tegc_pkg::TAP_MS) && (agdx < TAP_W) && (agdy < TAP_W);
	assign is_swipe = (dur < tegc_pkg::HOLD_MS) && ((agdx > SWIPE_W) || (agdy > SWIPE_W));

	always_comb begin
		priority if (is_tap) begin
			gk = tegc_pkg::GS_TAP;
		end else if (is_swipe && (agdx > agdy)) begin
			gk = (!gdx[C] && gdx != '0) ? tegc_pkg::GS_RIGHT : tegc_pkg::GS_LEFT;
		end else if (is_swipe) begin
			gk = (!gdy[C] && gdy != '0) ? tegc_pkg::GS_DOWN : tegc_pkg::GS_UP;
		end else begin
			gk = tegc_pkg::GS_NONE;
		end
	end

	always_comb begin
		pressed_nxt          = pressed_q;
		start_time_nxt       = start_time_q;
		start_x_nxt          = start_x_q;
		start_y_nxt          = start_y_q;
		last_x_nxt           = last_x_q;
		last_y_nxt           = last_y_q;
		ctl.event_kind       = tegc_pkg::EV_NONE;
		ctl.gesture_kind     = tegc_pkg::GS_NONE;
		event_x              = '0;
		event_y              = '0;
		held_ms              = '0;
		gesture_dx           = '0;
		gesture_dy           = '0;
		if (en) begin
			if (pressed) begin
				if (!pressed_q) begin
					pressed_nxt    = 1'b1;
					start_time_nxt = now_ms;
					start_x_nxt    = sample_x;
					start_y_nxt    = sample_y;
					last_x_nxt     = sample_x;
					last_y_nxt     = sample_y;
					ctl.event_kind = tegc_pkg::EV_DOWN;
					event_x        = sample_x;
					event_y        = sample_y;
				end else if (is_move) begin
					ctl.event_kind = tegc_pkg::EV_MOVE;
					event_x        = sample_x;
					event_y        = sample_y;
					held_ms        = dur;
					last_x_nxt     = sample_x;
					last_y_nxt     = sample_y;
				end else if (dur > tegc_pkg::HOLD_MS) begin
					ctl.event_kind = tegc_pkg::EV_HOLD;
					event_x        = sample_x;
					event_y        = sample_y;
					held_ms        = dur;
				end
			end else if (pressed_q) begin
				pressed_nxt      = 1'b0;
				ctl.event_kind   = tegc_pkg::EV_UP;
				event_x          = last_x_q;
				event_y          = last_y_q;
				held_ms          = dur;
				ctl.gesture_kind = gk;
				if (gk != tegc_pkg::GS_NONE) begin
					gesture_dx = gdx;
					gesture_dy = gdy;
				end
			end
		end
		ctl.touch_active = pressed_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			start_time_q <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
		end else if (fire) begin
			pressed_q    <= pressed_nxt;
			start_time_q <= start_time_nxt;
			start_x_q    <= start_x_nxt;
			start_y_q    <= start_y_nxt;
			last_x_q     <= last_x_nxt;
			last_y_q     <= last_y_nxt;
		end
	end

endmodule

`default_nettype wire

[design/touch_event_gesture_classifier.sv]
// channel | dir | fields (lsb first)
// s_*     | in  | tdata: pressed, sample_x, sample_y, now_ms
// m_*     | out | tdata: event_kind, event_x, event_y, held_ms, gesture_kind,
//         |     |        gesture_dx, gesture_dy, touch_active
// cfg_*   | in  | index 0 enabled, index 1 move_threshold (clamped 1..10)
//
// One request per cycle while m_tready is high; each request passes an input register and a result register.
// Touch state updates when a request moves from the input to the result register.
// m_tready low stalls the result register and then the input register.
// arst_n clears touch state and valid flags and sets the config registers to their reset values.
`default_nettype none

module touch_event_gesture_classifier #(
	parameter int unsigned COORD_BITS = tegc_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// pressed, sample_x, sample_y, now_ms
	input  wire logic [((33+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// event_kind, event_x, event_y, held_ms, gesture_kind, gesture_dx, gesture_dy, touch_active
	output logic [((41+4*COORD_BITS+7)/8)*8-1:0] m_tdata,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [3:0]                   cfg_wdata
);

	localparam int unsigned C      = COORD_BITS;
	localparam int unsigned OUT_TW = ((41+4*COORD_BITS+7)/8)*8;

	logic        en_q;
	logic [3:0]  thr_q;

	logic        valid_s1;
	logic        pressed_s1;
	logic [C-1:0] x_s1, y_s1;
	logic [31:0] now_s1;

	logic        adv, fire;

	tegc_pkg::evt_ctl_t ctl, ctl_s2;
	logic [C-1:0]       ex, ey, ex_s2, ey_s2;
	logic [31:0]        held, held_s2;
	logic signed [C:0]  gdx, gdy, gdx_s2, gdy_s2;
	logic               m_tvalid_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign fire     = adv && valid_s1;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			thr_q <= tegc_pkg::THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tegc_pkg::CFG_ENABLED: en_q <= cfg_wdata[0];
				tegc_pkg::CFG_THRESH: begin
					priority if (cfg_wdata < tegc_pkg::THR_MIN) begin
						thr_q <= tegc_pkg::THR_MIN;
					end else if (cfg_wdata > tegc_pkg::THR_MAX) begin
						thr_q <= tegc_pkg::THR_MAX;
					end else begin
						thr_q <= cfg_wdata;
					end
				end
				default: en_q <= en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pressed_s1 <= s_tdata[0];
			x_s1       <= s_tdata[C:1];
			y_s1       <= s_tdata[2*C:C+1];
			now_s1     <= s_tdata[2*C+32:2*C+1];
		end
	end

	tegc_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_q),
		.thr       (thr_q),
		.fire      (fire),
		.pressed   (pressed_s1),
		.sample_x  (x_s1),
		.sample_y  (y_s1),
		.now_ms    (now_s1),
		.ctl       (ctl),
		.event_x   (ex),
		.event_y   (ey),
		.held_ms   (held),
		.gesture_dx(gdx),
		.gesture_dy(gdy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s2  <= ctl;
			ex_s2   <= ex;
			ey_s2   <= ey;
			held_s2 <= held;
			gdx_s2  <= gdx;
			gdy_s2  <= gdy;
		end
	end

	assign m_tdata = OUT_TW'({ctl_s2.touch_active, gdy_s2, gdx_s2, ctl_s2.gesture_kind,
		held_s2, ey_s2, ex_s2, ctl_s2.event_kind});

`ifndef SYNTH
	a_gesture_only_on_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && ctl_s2.gesture_kind != tegc_pkg::GS_NONE |->
		ctl_s2.event_kind == tegc_pkg::EV_UP)
		else $error("gesture reported without up event");

	a_down_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && ctl_s2.event_kind == tegc_pkg::EV_DOWN |->
		ctl_s2.touch_active && held_s2 == '0)
		else $error("down event with bad state or duration");

	a_up_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && ctl_s2.event_kind == tegc_pkg::EV_UP |-> !ctl_s2.touch_active)
		else $error("up event leaves touch active");

	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		thr_q >= tegc_pkg::THR_MIN && thr_q <= tegc_pkg::THR_MAX)
		else $error("move threshold out of range");
`endif

endmodule

`default_nettype wire
